// ===== hdl/ffcu_pkg.sv =====
// Shared types, constants and table helpers for the free-flight camera update block.
`default_nettype none

package ffcu_pkg;

  // Angles are in 1/64 degree
  localparam int QUARTER          = 5760;
  localparam int HALF_TURN        = 11520;
  localparam int THREE_QUARTER    = 17280;
  localparam int FULL_TURN        = 23040;
  localparam int PITCH_LIMIT      = 5696;
  localparam int YAW_RESET        = 17280;
  localparam int ROM_AW           = $clog2(QUARTER);
  localparam int SINE_TABLE_DEPTH_DEF = 5760;

  localparam logic [63:0] PH_Q30  = 64'd1686629713;
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
  localparam logic [63:0] ONE_Q14 = 64'd16384;

  localparam logic signed [15:0] UNIT_POS = 16'sd16384;
  localparam logic signed [15:0] UNIT_NEG = -16'sd16384;

  typedef enum logic [2:0] {
    ACT_MOVE_FRONT = 3'd0,
    ACT_MOVE_RIGHT = 3'd1,
    ACT_MOVE_UP    = 3'd2,
    ACT_ADD_YAW    = 3'd3,
    ACT_ADD_PITCH  = 3'd4,
    ACT_RECOMPUTE  = 3'd5,
    ACT_SET_YAW    = 3'd6,
    ACT_SET_PITCH  = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    CFG_WORLD_UP_X = 2'd0,
    CFG_WORLD_UP_Y = 2'd1,
    CFG_WORLD_UP_Z = 2'd2
  } cfg_reg_t;

  // One command word held in the input stage, with the angles after it
  typedef struct packed {
    action_t              action;
    logic signed [15:0]   amount;
    logic        [14:0]   yaw;
    logic signed [15:0]   pitch;
  } item_t;

  typedef struct packed {
    logic signed [15:0] sin_q;
    logic signed [15:0] cos_q;
  } trig_t;

  // Reduce an angle into 0 .. FULL_TURN-1; valid for -2 to +3 turns
  function automatic logic [14:0] wrap_turn(input logic signed [17:0] v);
    logic signed [17:0] turn;
    logic signed [17:0] t;
    turn = 18'(FULL_TURN);
    if (v < 18'sd0) begin
      t = v + turn;
      if (t < 18'sd0) begin
        t = t + turn;
      end
    end else if (v >= turn) begin
      t = v - turn;
      if (t >= turn) begin
        t = t - turn;
      end
    end else begin
      t = v;
    end
    return t[14:0];
  endfunction

  // Q14 sine of a Q30 angle: degree-11 Taylor series in Horner form,
  // every product and quotient truncated, rounded half up and capped
  function automatic logic [14:0] sine_q14(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] r;
    x2 = (x * x) >> 30;
    t  = ONE_Q30 - x2 / 64'd110;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    r  = (s + 64'd32768) >> 16;
    if (r > ONE_Q14) begin
      r = ONE_Q14;
    end
    return r[14:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/free_flight_camera_update.sv =====
// Free-flight camera update: top level with handshake, configuration and stages.
//
// Usage: each command word on the in_ channel (action, amount) moves the camera,
// changes its angles or recomputes its vectors; the out_ channel returns one
// word per command with the full camera state after it. The user must write the
// world-up vector on the cfg_ port only while the block is idle; the block does
// not enforce this. Indexes past the world-up registers are ignored.
// The accepting edge latches the command, updates yaw and pitch and reads the
// sine table (registered read); when the input stage then moves into the free
// result register, that edge applies the move or recompute, loads the result
// registers and raises out_valid. Throughput: one command per cycle, set by the
// single result stage that also holds the camera state, while out_stall is low.
// Reset: position zero, front (0,0,-1), right (-1,0,0), yaw -90 degrees, pitch
// zero, world up (0,1,0); both stages empty.
// Stall: a held result keeps its word; one more command can wait in the input
// stage, after which in_stall rises in the same cycle as out_stall.
`default_nettype none

module free_flight_camera_update #(
  parameter int SINE_TABLE_DEPTH = ffcu_pkg::SINE_TABLE_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic        [1:0]     cfg_index,
  input  wire logic        [15:0]    cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic        [2:0]     in_action,
  input  wire logic signed [15:0]    in_amount,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic signed [31:0]         out_pos_x,
  output logic signed [31:0]         out_pos_y,
  output logic signed [31:0]         out_pos_z,
  output logic signed [15:0]         out_front_x,
  output logic signed [15:0]         out_front_y,
  output logic signed [15:0]         out_front_z,
  output logic signed [15:0]         out_right_x,
  output logic signed [15:0]         out_right_y,
  output logic signed [15:0]         out_right_z,
  output logic        [14:0]         out_yaw_now,
  output logic signed [15:0]         out_pitch_now
);

  logic signed [15:0] world_up_x_r;
  logic signed [15:0] world_up_y_r;
  logic signed [15:0] world_up_z_r;

  logic               s1_valid_r;
  logic               s1_valid_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic               out_free;
  logic               s1_adv;
  logic               in_accept;
  ffcu_pkg::item_t    item_r;
  ffcu_pkg::action_t  in_act;

  logic        [14:0] yaw_rd;
  logic        [14:0] pitch_rd;
  logic        [14:0] yaw_nxt;
  logic signed [15:0] pitch_nxt;
  ffcu_pkg::trig_t    trig_yaw;
  ffcu_pkg::trig_t    trig_pitch;

  assign in_act = ffcu_pkg::action_t'(in_action);

  // Handshake: input stage advances when the result register is free
  always_comb begin
    out_free      = !out_valid_r || !out_stall;
    s1_adv        = s1_valid_r && out_free;
    in_stall      = s1_valid_r && !out_free;
    in_accept     = in_valid && !in_stall;
    s1_valid_nxt  = in_accept || (s1_valid_r && !s1_adv);
    out_valid_nxt = s1_adv || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r.action <= in_act;
      item_r.amount <= in_amount;
      item_r.yaw    <= yaw_nxt;
      item_r.pitch  <= pitch_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      world_up_x_r <= '0;
      world_up_y_r <= ffcu_pkg::UNIT_POS;
      world_up_z_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ffcu_pkg::CFG_WORLD_UP_X: world_up_x_r <= cfg_wdata;
        ffcu_pkg::CFG_WORLD_UP_Y: world_up_y_r <= cfg_wdata;
        ffcu_pkg::CFG_WORLD_UP_Z: world_up_z_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  ffcu_angle_track u_angle (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .action    (in_act),
    .amount    (in_amount),
    .yaw_rd    (yaw_rd),
    .pitch_rd  (pitch_rd),
    .yaw_nxt   (yaw_nxt),
    .pitch_nxt (pitch_nxt)
  );

  ffcu_trig_rom #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_rom_yaw (
    .clk   (clk),
    .rd_en (in_accept),
    .angle (yaw_rd),
    .trig  (trig_yaw)
  );

  ffcu_trig_rom #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_rom_pitch (
    .clk   (clk),
    .rd_en (in_accept),
    .angle (pitch_rd),
    .trig  (trig_pitch)
  );

  ffcu_state_update u_update (
    .clk        (clk),
    .rst_n      (rst_n),
    .commit     (s1_adv),
    .item       (item_r),
    .trig_yaw   (trig_yaw),
    .trig_pitch (trig_pitch),
    .world_up_x (world_up_x_r),
    .world_up_y (world_up_y_r),
    .world_up_z (world_up_z_r),
    .pos_x      (out_pos_x),
    .pos_y      (out_pos_y),
    .pos_z      (out_pos_z),
    .front_x    (out_front_x),
    .front_y    (out_front_y),
    .front_z    (out_front_z),
    .right_x    (out_right_x),
    .right_y    (out_right_y),
    .right_z    (out_right_z),
    .yaw_now    (out_yaw_now),
    .pitch_now  (out_pitch_now)
  );

  assign out_valid = out_valid_r;

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> s1_valid_r)
    else $error("accepted word did not reach the input stage");

  a_yaw_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
    out_yaw_now < 15'(ffcu_pkg::FULL_TURN))
    else $error("yaw left the 0..360 degree range");

  a_pitch_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && item_r.action == ffcu_pkg::ACT_ADD_PITCH) |=>
      (out_pitch_now <= 16'sd5696 && out_pitch_now >= -16'sd5696))
    else $error("pitch add escaped the clamp");

  a_vectors_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_adv && item_r.action == ffcu_pkg::ACT_RECOMPUTE) |=>
      ($stable(out_front_x) && $stable(out_front_y) && $stable(out_front_z) &&
       $stable(out_right_x) && $stable(out_right_z)))
    else $error("direction vectors changed without a recompute");

  a_right_flat: assert property (@(posedge clk) disable iff (!rst_n)
    out_right_y == 16'sd0)
    else $error("right vector left the horizontal plane");

endmodule

`default_nettype wire

// ===== hdl/ffcu_trig_rom.sv =====
// Quarter-wave sine/cosine lookup with registered read for one angle.
`default_nettype none

module ffcu_trig_rom #(
  parameter int SINE_TABLE_DEPTH = ffcu_pkg::SINE_TABLE_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic [14:0]   angle,
  output ffcu_pkg::trig_t    trig
);

  // Each entry holds the table value at the scaled index and at its mirror
  logic [29:0] rom_w [ffcu_pkg::QUARTER];

  for (genvar gi = 0; gi < ffcu_pkg::QUARTER; gi++) begin : g_rom
    localparam logic [63:0] KG = (64'(gi) * 64'(SINE_TABLE_DEPTH)) / 64'(ffcu_pkg::QUARTER);
    localparam logic [63:0] KH = 64'(SINE_TABLE_DEPTH) - KG;
    localparam logic [63:0] XG = (KG * ffcu_pkg::PH_Q30) / 64'(SINE_TABLE_DEPTH);
    localparam logic [63:0] XH = (KH * ffcu_pkg::PH_Q30) / 64'(SINE_TABLE_DEPTH);
    localparam logic [14:0] VG = ffcu_pkg::sine_q14(XG);
    localparam logic [14:0] VH = ffcu_pkg::sine_q14(XH);
    assign rom_w[gi] = {VH, VG};
  end

  logic [1:0]                  quad;
  logic [14:0]                 rem_full;
  logic [1:0]                  quad_r;
  logic [14:0]                 val_g_r;
  logic [14:0]                 val_h_r;
  logic signed [15:0]          val_g;
  logic signed [15:0]          val_h;
  logic signed [15:0]          sin_mag;
  logic signed [15:0]          cos_mag;

  always_comb begin
    if (angle >= 15'(ffcu_pkg::THREE_QUARTER)) begin
      quad     = 2'd3;
      rem_full = angle - 15'(ffcu_pkg::THREE_QUARTER);
    end else if (angle >= 15'(ffcu_pkg::HALF_TURN)) begin
      quad     = 2'd2;
      rem_full = angle - 15'(ffcu_pkg::HALF_TURN);
    end else if (angle >= 15'(ffcu_pkg::QUARTER)) begin
      quad     = 2'd1;
      rem_full = angle - 15'(ffcu_pkg::QUARTER);
    end else begin
      quad     = 2'd0;
      rem_full = angle;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      quad_r  <= quad;
      val_g_r <= rom_w[rem_full[ffcu_pkg::ROM_AW-1:0]][14:0];
      val_h_r <= rom_w[rem_full[ffcu_pkg::ROM_AW-1:0]][29:15];
    end
  end

  // Odd quadrants read the mirrored entry; cosine sits one quadrant ahead
  always_comb begin
    val_g   = $signed({1'b0, val_g_r});
    val_h   = $signed({1'b0, val_h_r});
    sin_mag = quad_r[0] ? val_h : val_g;
    cos_mag = quad_r[0] ? val_g : val_h;
    trig.sin_q = quad_r[1] ? -sin_mag : sin_mag;
    trig.cos_q = (quad_r[0] ^ quad_r[1]) ? -cos_mag : cos_mag;
  end

endmodule

`default_nettype wire

// ===== hdl/ffcu_angle_track.sv =====
// Yaw and pitch tracking, updated as each command word is accepted.
`default_nettype none

module ffcu_angle_track (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  accept,
  input  wire ffcu_pkg::action_t     action,
  input  wire logic signed [15:0]    amount,
  output logic        [14:0]         yaw_rd,
  output logic        [14:0]         pitch_rd,
  output logic        [14:0]         yaw_nxt,
  output logic signed [15:0]         pitch_nxt
);

  logic        [14:0] yaw_r;
  logic signed [15:0] pitch_r;
  logic signed [17:0] yaw_sum;
  logic signed [16:0] pitch_sum;

  always_comb begin
    yaw_sum   = $signed({3'b000, yaw_r}) + 18'(amount);
    pitch_sum = 17'(pitch_r) + 17'(amount);
    yaw_nxt   = yaw_r;
    pitch_nxt = pitch_r;
    case (action)
      ffcu_pkg::ACT_ADD_YAW: begin
        yaw_nxt = ffcu_pkg::wrap_turn(yaw_sum);
      end
      ffcu_pkg::ACT_SET_YAW: begin
        yaw_nxt = ffcu_pkg::wrap_turn(18'(amount));
      end
      ffcu_pkg::ACT_ADD_PITCH: begin
        // clamp to plus or minus 89 degrees
        if (pitch_sum > 17'(ffcu_pkg::PITCH_LIMIT)) begin
          pitch_nxt = 16'(ffcu_pkg::PITCH_LIMIT);
        end else if (pitch_sum < -17'(ffcu_pkg::PITCH_LIMIT)) begin
          pitch_nxt = -16'(ffcu_pkg::PITCH_LIMIT);
        end else begin
          pitch_nxt = pitch_sum[15:0];
        end
      end
      ffcu_pkg::ACT_SET_PITCH: begin
        pitch_nxt = amount;
      end
      default: begin
      end
    endcase
  end

  // Table reads use the angles before the word; a recompute leaves them alone
  assign yaw_rd   = yaw_r;
  assign pitch_rd = ffcu_pkg::wrap_turn(18'(pitch_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      yaw_r   <= 15'(ffcu_pkg::YAW_RESET);
      pitch_r <= '0;
    end else if (accept) begin
      yaw_r   <= yaw_nxt;
      pitch_r <= pitch_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ffcu_state_update.sv =====
// Camera position and direction vector update, committed into the result registers.
`default_nettype none

module ffcu_state_update (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  commit,
  input  wire ffcu_pkg::item_t       item,
  input  wire ffcu_pkg::trig_t       trig_yaw,
  input  wire ffcu_pkg::trig_t       trig_pitch,
  input  wire logic signed [15:0]    world_up_x,
  input  wire logic signed [15:0]    world_up_y,
  input  wire logic signed [15:0]    world_up_z,
  output logic signed [31:0]         pos_x,
  output logic signed [31:0]         pos_y,
  output logic signed [31:0]         pos_z,
  output logic signed [15:0]         front_x,
  output logic signed [15:0]         front_y,
  output logic signed [15:0]         front_z,
  output logic signed [15:0]         right_x,
  output logic signed [15:0]         right_y,
  output logic signed [15:0]         right_z,
  output logic        [14:0]         yaw_now,
  output logic signed [15:0]         pitch_now
);

  logic signed [31:0] pos_r     [3];
  logic signed [31:0] pos_nxt   [3];
  logic signed [15:0] front_r   [3];
  logic signed [15:0] front_nxt [3];
  logic signed [15:0] right_r   [3];
  logic signed [15:0] right_nxt [3];
  logic        [14:0] yaw_now_r;
  logic signed [15:0] pitch_now_r;

  logic signed [15:0] up_w      [3];
  logic signed [15:0] op_a      [3];
  logic signed [15:0] op_b      [3];
  logic signed [31:0] prod      [3];
  logic signed [32:0] move_rnd  [3];
  logic signed [26:0] delta     [3];
  logic signed [33:0] pos_sum   [3];
  logic signed [31:0] pos_sat   [3];
  logic signed [32:0] vec_rnd   [3];

  assign up_w[0] = world_up_x;
  assign up_w[1] = world_up_y;
  assign up_w[2] = world_up_z;

  // Operand select: one shared multiplier per axis
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      op_a[i] = item.amount;
      op_b[i] = '0;
    end
    case (item.action)
      ffcu_pkg::ACT_MOVE_FRONT: begin
        for (int i = 0; i < 3; i++) begin
          op_b[i] = front_r[i];
        end
      end
      ffcu_pkg::ACT_MOVE_RIGHT: begin
        for (int i = 0; i < 3; i++) begin
          op_b[i] = right_r[i];
        end
      end
      ffcu_pkg::ACT_MOVE_UP: begin
        for (int i = 0; i < 3; i++) begin
          op_b[i] = up_w[i];
        end
      end
      ffcu_pkg::ACT_RECOMPUTE: begin
        op_a[0] = trig_yaw.cos_q;
        op_b[0] = trig_pitch.cos_q;
        op_a[2] = trig_yaw.sin_q;
        op_b[2] = trig_pitch.cos_q;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod[i]     = op_a[i] * op_b[i];
      move_rnd[i] = 33'(prod[i]) + 33'sd32;
      delta[i]    = move_rnd[i][32:6];
      pos_sum[i]  = 34'(pos_r[i]) + 34'(delta[i]);
      // saturate when the top three bits disagree
      if (pos_sum[i][33:31] == 3'b000 || pos_sum[i][33:31] == 3'b111) begin
        pos_sat[i] = pos_sum[i][31:0];
      end else if (pos_sum[i][33]) begin
        pos_sat[i] = 32'sh8000_0000;
      end else begin
        pos_sat[i] = 32'sh7fff_ffff;
      end
      vec_rnd[i] = (33'(prod[i]) + 33'sd8192) >>> 14;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pos_nxt[i]   = pos_r[i];
      front_nxt[i] = front_r[i];
      right_nxt[i] = right_r[i];
    end
    case (item.action)
      ffcu_pkg::ACT_MOVE_FRONT, ffcu_pkg::ACT_MOVE_RIGHT, ffcu_pkg::ACT_MOVE_UP: begin
        for (int i = 0; i < 3; i++) begin
          pos_nxt[i] = pos_sat[i];
        end
      end
      ffcu_pkg::ACT_RECOMPUTE: begin
        front_nxt[0] = vec_rnd[0][15:0];
        front_nxt[1] = trig_pitch.sin_q;
        front_nxt[2] = vec_rnd[2][15:0];
        right_nxt[0] = trig_yaw.sin_q;
        right_nxt[1] = '0;
        right_nxt[2] = -trig_yaw.cos_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        pos_r[i] <= '0;
      end
      front_r[0]  <= '0;
      front_r[1]  <= '0;
      front_r[2]  <= ffcu_pkg::UNIT_NEG;
      right_r[0]  <= ffcu_pkg::UNIT_NEG;
      right_r[1]  <= '0;
      right_r[2]  <= '0;
      yaw_now_r   <= 15'(ffcu_pkg::YAW_RESET);
      pitch_now_r <= '0;
    end else if (commit) begin
      for (int i = 0; i < 3; i++) begin
        pos_r[i]   <= pos_nxt[i];
        front_r[i] <= front_nxt[i];
        right_r[i] <= right_nxt[i];
      end
      yaw_now_r   <= item.yaw;
      pitch_now_r <= item.pitch;
    end
  end

  assign pos_x     = pos_r[0];
  assign pos_y     = pos_r[1];
  assign pos_z     = pos_r[2];
  assign front_x   = front_r[0];
  assign front_y   = front_r[1];
  assign front_z   = front_r[2];
  assign right_x   = right_r[0];
  assign right_y   = right_r[1];
  assign right_z   = right_r[2];
  assign yaw_now   = yaw_now_r;
  assign pitch_now = pitch_now_r;

endmodule

`default_nettype wire
